// ===== sv/psu_pkg.sv =====
// Shared types, codes and constants for the precharge supervisor.
`default_nettype none
package psu_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned VoltW  = 16;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned StatW  = 3;
    localparam int unsigned FaultW = 2;
    localparam int unsigned CfgIdxW = 3;

    // status codes
    localparam logic [StatW-1:0] ST_IDLE    = 3'd0;
    localparam logic [StatW-1:0] ST_RUNNING = 3'd1;
    localparam logic [StatW-1:0] ST_OK      = 3'd2;
    localparam logic [StatW-1:0] ST_TIMEOUT = 3'd3;
    localparam logic [StatW-1:0] ST_PLATEAU = 3'd4;
    localparam logic [StatW-1:0] ST_TAU     = 3'd5;

    // fault codes
    localparam logic [FaultW-1:0] FAULT_NONE    = 2'd0;
    localparam logic [FaultW-1:0] FAULT_TIMEOUT = 2'd1;
    localparam logic [FaultW-1:0] FAULT_PLATEAU = 2'd2;
    localparam logic [FaultW-1:0] FAULT_TAU     = 2'd3;

    // opcodes and contactor states
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;
    localparam logic [1:0] CONT_OPEN      = 2'd0;
    localparam logic [1:0] CONT_PRECHARGE = 2'd1;
    localparam logic [1:0] CONT_CLOSED    = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PLATEAU   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LOW_FRAC  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_TAU   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SAFE_VOLT = 3'd4;

    // register reset values
    localparam logic [CfgW-1:0] TIMEOUT_RST   = 16'd2000;
    localparam logic [CfgW-1:0] PLATEAU_RST   = 16'd200;
    localparam logic [CfgW-1:0] LOW_FRAC_RST  = 16'd3277;
    localparam logic [CfgW-1:0] MIN_TAU_RST   = 16'd10;
    localparam logic [CfgW-1:0] SAFE_VOLT_RST = 16'd1920;

    typedef struct packed {
        logic [CfgW-1:0] timeout_ms;
        logic [CfgW-1:0] plateau_ms;
        logic [CfgW-1:0] low_fraction;
        logic [CfgW-1:0] min_tau_ms;
        logic [CfgW-1:0] safe_voltage;
    } psu_cfg_t;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [TimeW-1:0] start_time;
        logic [VoltW-1:0] start_voltage;
        logic [VoltW-1:0] peak_voltage;
        logic [TimeW-1:0] peak_time;
        logic             rise_done;
        logic [TimeW-1:0] rise_time;
    } psu_state_t;

endpackage
`default_nettype wire

// ===== sv/psu_step.sv =====
// Next-state and verdict logic for one precharge sample beat.
`default_nettype none
module psu_step
    import psu_pkg::*;
(
    input  psu_cfg_t           cfg,
    input  psu_state_t         cur,
    input  logic               opcode,
    input  logic [1:0]         contactor_state,
    input  logic               link_valid,
    input  logic [VoltW-1:0]   link_voltage,
    input  logic [VoltW-1:0]   pack_voltage,
    input  logic               pack_recent,
    input  logic [TimeW-1:0]   now_ms,
    output psu_state_t         nxt,
    output logic [FaultW-1:0]  fault
);

    logic               is_idle;
    logic [TimeW-1:0]   st_time;
    logic [VoltW-1:0]   st_volt;
    logic [VoltW-1:0]   pk_volt;
    logic [TimeW-1:0]   pk_time;
    logic               usable;
    logic               timed_out;
    logic signed [16:0] rise;
    logic signed [16:0] step;
    logic signed [26:0] rise_scaled;
    logic signed [26:0] step_scaled;
    logic               rise_hit;
    logic               rise_done_upd;
    logic [TimeW-1:0]   rise_time_upd;
    logic [24:0]        link_x500;
    logic [25:0]        peak_thresh;
    logic               new_max;
    logic [VoltW-1:0]   pk_volt_upd;
    logic [TimeW-1:0]   pk_time_upd;
    logic               plateau;
    logic [16:0]        keep_frac;
    logic [32:0]        low_limit;
    logic               low_link;
    logic               short_tau;

    // start step takes its reference values from the current beat
    assign is_idle = (cur.status == ST_IDLE);
    assign st_time = is_idle ? now_ms : cur.start_time;
    assign st_volt = is_idle ? (link_valid ? link_voltage : '0) : cur.start_voltage;
    assign pk_volt = is_idle ? st_volt : cur.peak_voltage;
    assign pk_time = is_idle ? now_ms : cur.peak_time;

    assign timed_out = (now_ms - st_time) >= TimeW'(cfg.timeout_ms);
    assign usable    = link_valid && pack_recent && (pack_voltage > cfg.safe_voltage);

    // 63.2% point: 1000*(link-start) >= 632*(pack-start)
    assign rise        = $signed({1'b0, link_voltage}) - $signed({1'b0, st_volt});
    assign step        = $signed({1'b0, pack_voltage}) - $signed({1'b0, st_volt});
    assign rise_scaled = $signed({{10{rise[16]}}, rise}) * 27'sd1000;
    assign step_scaled = $signed({{10{step[16]}}, step}) * 27'sd632;
    assign rise_hit    = !cur.rise_done && (rise_scaled >= step_scaled);
    assign rise_done_upd = cur.rise_done || rise_hit;
    assign rise_time_upd = rise_hit ? (now_ms - st_time) : cur.rise_time;

    // new maximum needs 0.2% of pack above the old peak
    assign link_x500   = 25'(link_voltage) * 25'd500;
    assign peak_thresh = 26'(25'(pk_volt) * 25'd500) + 26'(pack_voltage);
    assign new_max     = {1'b0, link_x500} > peak_thresh;
    assign pk_volt_upd = new_max ? link_voltage : pk_volt;
    assign pk_time_upd = new_max ? now_ms : pk_time;

    assign plateau   = rise_done_upd && ((now_ms - pk_time_upd) >= TimeW'(cfg.plateau_ms));
    assign keep_frac = 17'h10000 - 17'(cfg.low_fraction);
    assign low_limit = 33'(pack_voltage) * 33'(keep_frac);
    assign low_link  = {1'b0, link_voltage, 16'h0000} < low_limit;
    assign short_tau = rise_done_upd && (rise_time_upd < TimeW'(cfg.min_tau_ms));

    always_comb begin
        nxt   = cur;
        fault = FAULT_NONE;
        if (opcode == OP_RESTART) begin
            nxt        = '0;
            nxt.status = ST_IDLE;
        end else if (cur.status == ST_IDLE || cur.status == ST_RUNNING) begin
            if (!is_idle || contactor_state == CONT_PRECHARGE) begin
                nxt.status        = ST_RUNNING;
                nxt.start_time    = st_time;
                nxt.start_voltage = st_volt;
                nxt.peak_voltage  = pk_volt;
                nxt.peak_time     = pk_time;
                if (timed_out) begin
                    nxt.status = ST_TIMEOUT;
                    fault      = FAULT_TIMEOUT;
                end else if (usable) begin
                    nxt.rise_done    = rise_done_upd;
                    nxt.rise_time    = rise_time_upd;
                    nxt.peak_voltage = pk_volt_upd;
                    nxt.peak_time    = pk_time_upd;
                    if (plateau || contactor_state == CONT_CLOSED) begin
                        priority if (low_link) begin
                            nxt.status = ST_PLATEAU;
                            fault      = FAULT_PLATEAU;
                        end else if (short_tau) begin
                            nxt.status = ST_TAU;
                            fault      = FAULT_TAU;
                        end else begin
                            nxt.status = ST_OK;
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/precharge_supervisor_unit.sv =====
// Top level of the precharge supervisor: registers, handshakes, result register.
//
//   channel | direction | handshake             | payload
//   s_      | in        | s_valid / s_ready     | opcode, contactor, link, pack, now_ms
//   m_      | out       | m_valid / m_ready     | status, fault, rise time, rise seen
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle while s_ready is high; state and result registers both
// load at the end of the accepting cycle. The state feedback through the step
// logic sets the cycle time. s_ready drops only while a result is held and
// m_ready is low. Synchronous reset clears state and loads register defaults.
`default_nettype none
module precharge_supervisor_unit
    import psu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_opcode,
    input  wire logic [1:0]         s_contactor_state,
    input  wire logic               s_link_valid,
    input  wire logic [VoltW-1:0]   s_link_voltage,
    input  wire logic [VoltW-1:0]   s_pack_voltage,
    input  wire logic               s_pack_recent,
    input  wire logic [TimeW-1:0]   s_now_ms,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [StatW-1:0]        m_status,
    output logic [FaultW-1:0]       m_fault_raised,
    output logic [TimeW-1:0]        m_rise_time_ms,
    output logic                    m_rise_seen,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [CfgW-1:0]    cfg_data
);

    psu_cfg_t          cfg_reg;
    psu_state_t        state_reg;
    psu_state_t        state_next;
    logic [FaultW-1:0] fault_next;
    logic              m_valid_reg;
    logic [StatW-1:0]  status_reg;
    logic [FaultW-1:0] fault_reg;
    logic [TimeW-1:0]  rise_time_reg;
    logic              rise_seen_reg;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    psu_step u_step (
        .cfg             (cfg_reg),
        .cur             (state_reg),
        .opcode          (s_opcode),
        .contactor_state (s_contactor_state),
        .link_valid      (s_link_valid),
        .link_voltage    (s_link_voltage),
        .pack_voltage    (s_pack_voltage),
        .pack_recent     (s_pack_recent),
        .now_ms          (s_now_ms),
        .nxt             (state_next),
        .fault           (fault_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms   <= TIMEOUT_RST;
            cfg_reg.plateau_ms   <= PLATEAU_RST;
            cfg_reg.low_fraction <= LOW_FRAC_RST;
            cfg_reg.min_tau_ms   <= MIN_TAU_RST;
            cfg_reg.safe_voltage <= SAFE_VOLT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TIMEOUT:   cfg_reg.timeout_ms   <= cfg_data;
                CFG_PLATEAU:   cfg_reg.plateau_ms   <= cfg_data;
                CFG_LOW_FRAC:  cfg_reg.low_fraction <= cfg_data;
                CFG_MIN_TAU:   cfg_reg.min_tau_ms   <= cfg_data;
                CFG_SAFE_VOLT: cfg_reg.safe_voltage <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= state_next.status;
            fault_reg     <= fault_next;
            rise_time_reg <= state_next.rise_time;
            rise_seen_reg <= state_next.rise_done;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_fault_raised = fault_reg;
    assign m_rise_time_ms = rise_time_reg;
    assign m_rise_seen    = rise_seen_reg;

endmodule
`default_nettype wire

// ===== sv/psu_checker.sv =====
// Port-level checks for the precharge supervisor, bound to the top level.
`default_nettype none
module psu_checker
    import psu_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [StatW-1:0]  m_status,
    input wire logic [FaultW-1:0] m_fault_raised,
    input wire logic [TimeW-1:0]  m_rise_time_ms,
    input wire logic              m_rise_seen
);

    // held result beat stays up
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // a fault always lands together with its matching refusal status
    a_fault_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_fault_raised == FAULT_NONE) ||
            (m_fault_raised == FAULT_TIMEOUT && m_status == ST_TIMEOUT) ||
            (m_fault_raised == FAULT_PLATEAU && m_status == ST_PLATEAU) ||
            (m_fault_raised == FAULT_TAU && m_status == ST_TAU))
        else $error("fault code disagrees with status");

    // rise time only reported once the 63 percent point is seen
    a_rise_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rise_seen |-> m_rise_time_ms == '0)
        else $error("rise time nonzero before rise point");

    // idle means nothing measured yet
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_IDLE |-> !m_rise_seen && m_fault_raised == FAULT_NONE)
        else $error("idle beat carries measurement or fault");

endmodule

bind precharge_supervisor_unit psu_checker u_psu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_fault_raised (m_fault_raised),
    .m_rise_time_ms (m_rise_time_ms),
    .m_rise_seen    (m_rise_seen)
);
`default_nettype wire
